[hw/rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, codes, state type and control structs of the rational unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

  // Word width of the operands; only the low WORD_BITS bits of each field count.
  localparam int WORD_BITS = 32;
  // A magnitude of a WORD_BITS-bit value reaches at most 2^(WORD_BITS-1); the
  // spare bit holds 2^WORD_BITS for the negate.
  localparam int MAG_BITS  = WORD_BITS + 1;
  // Products and sums of two products.
  localparam int PROD_BITS = 2 * MAG_BITS;
  localparam int CNT_BITS  = $clog2(PROD_BITS + 1);

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] MUL_FIRST  = 2'd0;
  localparam logic [1:0] MUL_SECOND = 2'd1;
  localparam logic [1:0] MUL_DEN    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_GCD,
    S_DIV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_idx;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } ctrl_t;

  typedef struct packed {
    logic err;
    logic gcd_done;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

[hw/rtl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies, divides or normalizes fractions, gcd reduced.
//
//   channel | valid       | stall        | fields
//   input   | in_valid_i  | in_stall_o   | cmd_i a_num_i a_den_i b_num_i b_den_i
//   output  | out_valid_o | out_stall_i  | res_num_o res_den_o status_o
//
// One item at a time. After the accepting edge the sequencer runs three multiply
// steps, the combine, the gcd steps, the divider steps and the result beat, then
// passes through idle before it takes the next beat.
// A zero denominator or divisor skips from the first multiply step to the result.
// Reset clears the sequencer and the output valid; data registers are not reset.
// A finished result waits in the output register while the next beat is taken;
// a result still stalled when the next one is ready holds the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic signed [31:0] a_num_i,
  input  wire logic signed [31:0] a_den_i,
  input  wire logic signed [31:0] b_num_i,
  input  wire logic signed [31:0] b_den_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      res_num_o,
  output logic [30:0]             res_den_o,
  output logic [1:0]              status_o
);
  import rau_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer.
  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Arithmetic.
  rau_dp u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .cmd_i    (cmd_i),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .res_num_o(res_num_o),
    .res_den_o(res_den_o),
    .status_o (status_o)
  );

endmodule

`default_nettype wire

[hw/rtl/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: multiply steps, gcd iterations, divisions and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire rau_pkg::stat_t stat_i,
  output rau_pkg::ctrl_t     ctrl_o
);
  import rau_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL;
          idx_d   = MUL_FIRST;
        end
      end
      S_MUL: begin
        if (idx_q == MUL_FIRST && stat_i.err) begin
          state_d = S_FIN;
        end else if (idx_q == MUL_DEN) begin
          state_d = S_COMB;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_COMB: state_d = S_GCD;
      S_GCD: begin
        if (stat_i.gcd_done) state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_idx = idx_q;
    out_valid_d    = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: ctrl_o.load = in_valid_i;
      S_MUL:  ctrl_o.mul_en = 1'b1;
      S_COMB: ctrl_o.gcd_init = 1'b1;
      S_GCD: begin
        if (stat_i.gcd_done) ctrl_o.div_init = 1'b1;
        else                 ctrl_o.gcd_step = 1'b1;
      end
      S_DIV: ctrl_o.div_step = !stat_i.div_done;
      S_FIN: begin
        if (out_free) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
        end
      end
      default: ctrl_o = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= MUL_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/rau_dp.sv]
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand split, shared multiplier, binary gcd, dual divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_dp (
  input  wire logic               clk_i,
  input  wire rau_pkg::ctrl_t     ctrl_i,
  output rau_pkg::stat_t          stat_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic signed [31:0] a_num_i,
  input  wire logic signed [31:0] a_den_i,
  input  wire logic signed [31:0] b_num_i,
  input  wire logic signed [31:0] b_den_i,
  output logic signed [31:0]      res_num_o,
  output logic [30:0]             res_den_o,
  output logic [1:0]              status_o
);
  import rau_pkg::*;

  localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (WORD_BITS - 1);

  function automatic logic [MAG_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] u);
    logic [MAG_BITS-1:0] full;
    full = {1'b1, {WORD_BITS{1'b0}}};
    return u[WORD_BITS-1] ? (full - {1'b0, u}) : {1'b0, u};
  endfunction

  logic [WORD_BITS-1:0] an_w, ad_w, bn_w, bd_w;
  logic [MAG_BITS-1:0]  an_q, ad_q, bn_q, bd_q;
  logic                 asg_q, bsg_q, norm_q, sub_q, muldiv_q, err_q;
  logic [PROD_BITS-1:0] p0_q, p1_q, p2_q;
  logic [PROD_BITS-1:0] m_q, d_q, gx_q, gy_q, g_q;
  logic                 neg_q;
  logic [CNT_BITS-1:0]  k_q, cnt_q;
  logic [PROD_BITS:0]   rm_q, rd_q;
  logic [PROD_BITS-1:0] qm_q, qd_q;
  logic                 err_w;

  assign an_w = a_num_i[WORD_BITS-1:0];
  assign ad_w = a_den_i[WORD_BITS-1:0];
  assign bn_w = b_num_i[WORD_BITS-1:0];
  assign bd_w = b_den_i[WORD_BITS-1:0];

  assign err_w = (ad_w == '0) || (cmd_i <= CMD_DIV && bd_w == '0) ||
                 (cmd_i == CMD_DIV && bn_w == '0);

  // Operand capture; divide swaps b for its reciprocal.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      an_q     <= mag_of(an_w);
      ad_q     <= mag_of(ad_w);
      asg_q    <= an_w[WORD_BITS-1] ^ ad_w[WORD_BITS-1];
      bsg_q    <= bn_w[WORD_BITS-1] ^ bd_w[WORD_BITS-1];
      bn_q     <= (cmd_i == CMD_DIV) ? mag_of(bd_w) : mag_of(bn_w);
      bd_q     <= (cmd_i == CMD_DIV) ? mag_of(bn_w) : mag_of(bd_w);
      norm_q   <= (cmd_i > CMD_DIV);
      sub_q    <= (cmd_i == CMD_SUB);
      muldiv_q <= (cmd_i == CMD_MUL) || (cmd_i == CMD_DIV);
      err_q    <= err_w;
    end
  end

  // Shared multiplier, one product per step; magnitudes fit in WORD_BITS bits.
  logic [WORD_BITS-1:0] op_x, op_y;
  logic [PROD_BITS-1:0] prod;
  always_comb begin
    case (ctrl_i.mul_idx)
      MUL_FIRST: begin
        op_x = an_q[WORD_BITS-1:0];
        op_y = muldiv_q ? bn_q[WORD_BITS-1:0] : bd_q[WORD_BITS-1:0];
      end
      MUL_SECOND: begin
        op_x = bn_q[WORD_BITS-1:0];
        op_y = ad_q[WORD_BITS-1:0];
      end
      default: begin
        op_x = ad_q[WORD_BITS-1:0];
        op_y = bd_q[WORD_BITS-1:0];
      end
    endcase
    prod = PROD_BITS'(op_x) * PROD_BITS'(op_y);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      case (ctrl_i.mul_idx)
        MUL_FIRST:  p0_q <= prod;
        MUL_SECOND: p1_q <= prod;
        default:    p2_q <= prod;
      endcase
    end
  end

  // Combine products, or the operands for normalize, into one unreduced numerator and denominator.
  logic [PROD_BITS-1:0] cm, cd;
  logic                 cneg, s2;
  always_comb begin
    s2 = bsg_q ^ sub_q;
    cd = p2_q;
    if (norm_q) begin
      cneg = asg_q;
      cm   = PROD_BITS'(an_q);
      cd   = PROD_BITS'(ad_q);
    end else if (muldiv_q) begin
      cneg = asg_q ^ bsg_q;
      cm   = p0_q;
    end else if (asg_q == s2) begin
      cneg = asg_q;
      cm   = p0_q + p1_q;
    end else if (p0_q >= p1_q) begin
      cneg = asg_q;
      cm   = p0_q - p1_q;
    end else begin
      cneg = s2;
      cm   = p1_q - p0_q;
    end
  end

  // Binary gcd, one step per cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.gcd_init) begin
      m_q   <= cm;
      d_q   <= cd;
      neg_q <= cneg && (cm != '0);
      gx_q  <= cm;
      gy_q  <= cd;
      k_q   <= '0;
    end else if (ctrl_i.gcd_step) begin
      if (!gx_q[0] && !gy_q[0]) begin
        gx_q <= gx_q >> 1;
        gy_q <= gy_q >> 1;
        k_q  <= k_q + CNT_BITS'(1);
      end else if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (!gy_q[0]) begin
        gy_q <= gy_q >> 1;
      end else if (gx_q > gy_q) begin
        gx_q <= (gx_q - gy_q) >> 1;
      end else begin
        gy_q <= (gy_q - gx_q) >> 1;
      end
    end
  end

  assign stat_o.gcd_done = (gx_q == gy_q) || (m_q == '0);
  assign stat_o.err      = err_q;
  assign stat_o.div_done = (cnt_q == CNT_BITS'(PROD_BITS));

  // Two restoring dividers sharing the gcd as divisor.
  logic [PROD_BITS:0] rm_s, rd_s;
  assign rm_s = {rm_q[PROD_BITS-1:0], qm_q[PROD_BITS-1]};
  assign rd_s = {rd_q[PROD_BITS-1:0], qd_q[PROD_BITS-1]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_init) begin
      g_q   <= (m_q == '0) ? d_q : (gx_q << k_q);
      rm_q  <= '0;
      rd_q  <= '0;
      qm_q  <= m_q;
      qd_q  <= d_q;
      cnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      cnt_q <= cnt_q + CNT_BITS'(1);
      if (rm_s >= {1'b0, g_q}) begin
        rm_q <= rm_s - {1'b0, g_q};
        qm_q <= {qm_q[PROD_BITS-2:0], 1'b1};
      end else begin
        rm_q <= rm_s;
        qm_q <= {qm_q[PROD_BITS-2:0], 1'b0};
      end
      if (rd_s >= {1'b0, g_q}) begin
        rd_q <= rd_s - {1'b0, g_q};
        qd_q <= {qd_q[PROD_BITS-2:0], 1'b1};
      end else begin
        rd_q <= rd_s;
        qd_q <= {qd_q[PROD_BITS-2:0], 1'b0};
      end
    end
  end

  // Range check and the output register.
  logic                        ovf;
  logic [PROD_BITS-1:0]        sval;
  logic signed [WORD_BITS-1:0] wval;
  always_comb begin
    ovf  = (neg_q ? (qm_q > HALF) : (qm_q > HALF - PROD_BITS'(1))) ||
           (qd_q > HALF - PROD_BITS'(1));
    sval = neg_q ? (PROD_BITS'(0) - qm_q) : qm_q;
    wval = $signed(sval[WORD_BITS-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      if (err_q) begin
        res_num_o <= '0;
        res_den_o <= '0;
        status_o  <= ST_ZERO_DEN;
      end else if (ovf) begin
        res_num_o <= '0;
        res_den_o <= '0;
        status_o  <= ST_OVERFLOW;
      end else begin
        res_num_o <= 32'(wval);
        res_den_o <= 31'(qd_q);
        status_o  <= ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

[dv/tb_rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Drives directed and random fraction operations into the rational unit and
// checks every result beat against a predictor of the reduced fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam logic [2:0] CMD_NORM = 3'd4;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_BEATS = 1750;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } op_beat_t;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  status;
  } frac_res_t;

  // Predicted reduced fraction for one operation.
  function automatic frac_res_t predict_fraction(op_beat_t op);
    frac_res_t r;
    logic [2:0] c;
    logic an, bn, rn, s1, s2;
    logic [127:0] am, ad, bm, bd, rm, rd, t1, t2, g, x, y, tmp;
    logic [127:0] half;
    c = op.cmd;
    half = 128'd1 << 31;
    r = '0;
    if (op.a_den == 0 || (c <= CMD_DIV && op.b_den == 0) ||
        (c == CMD_DIV && op.b_num == 0)) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    am = op.a_num[31] ? 128'(-$signed({1'b1, op.a_num})) : 128'(op.a_num);
    ad = op.a_den[31] ? 128'(-$signed({1'b1, op.a_den})) : 128'(op.a_den);
    an = op.a_num[31] ^ op.a_den[31];
    if (c == CMD_DIV) begin
      bm = op.b_den[31] ? 128'(-$signed({1'b1, op.b_den})) : 128'(op.b_den);
      bd = op.b_num[31] ? 128'(-$signed({1'b1, op.b_num})) : 128'(op.b_num);
    end else begin
      bm = op.b_num[31] ? 128'(-$signed({1'b1, op.b_num})) : 128'(op.b_num);
      bd = op.b_den[31] ? 128'(-$signed({1'b1, op.b_den})) : 128'(op.b_den);
    end
    bn = op.b_num[31] ^ op.b_den[31];
    if (c == CMD_ADD || c == CMD_SUB) begin
      t1 = am * bd;
      t2 = bm * ad;
      s1 = an;
      s2 = (c == CMD_SUB) ? !bn : bn;
      if (s1 == s2) begin
        rn = s1; rm = t1 + t2;
      end else if (t1 >= t2) begin
        rn = s1; rm = t1 - t2;
      end else begin
        rn = s2; rm = t2 - t1;
      end
      rd = ad * bd;
    end else if (c == CMD_MUL || c == CMD_DIV) begin
      rn = an ^ bn; rm = am * bm; rd = ad * bd;
    end else begin
      rn = an; rm = am; rd = ad;
    end
    // Euclid on exact magnitudes.
    x = rm; y = rd;
    while (y != 0) begin
      tmp = x % y; x = y; y = tmp;
    end
    g = x;
    rm = rm / g;
    rd = rd / g;
    if (rm == 0) rn = 1'b0;
    if ((rn ? (rm > half) : (rm > half - 1)) || rd > half - 1) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.num = rn ? 32'(-rm) : 32'(rm);
    r.den = rd[30:0];
    r.status = ST_OK;
    return r;
  endfunction

  // Scoreboard of expected reduced fractions.
  class fraction_scoreboard;
    frac_res_t pending[$];
    int errors;
    int checked;

    function void note_operation(op_beat_t op);
      pending.push_back(predict_fraction(op));
    endfunction

    function void check_result(frac_res_t got);
      frac_res_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected", 0, 0);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.status !== exp_r.status) report_mismatch("status", got.status, exp_r.status);
      if (got.num !== exp_r.num) report_mismatch("res_num", got.num, exp_r.num);
      if (got.den !== exp_r.den) report_mismatch("res_den", got.den, exp_r.den);
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %0d: %s got %0h want %0h", checked, what, got, want);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] cmd_i = '0;
  logic signed [31:0] a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic [1:0] status_o;

  fraction_scoreboard sb = new();
  op_beat_t ops[$];
  bit hold_off = 1'b0;
  bit sending_done = 1'b0;
  int idle_cycles = 0;
  int sent = 0;

  rational_arithmetic_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .out_valid_o, .out_stall_i, .res_num_o, .res_den_o,
    .status_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Pick a word that often hits the extremes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd1;
      4: return 32'd0;
      5: return 32'($signed($urandom_range(0, 40)) - 20);
      6: return 32'($urandom_range(0, 65535)) - 32'd32768;
      default: return $urandom();
    endcase
  endfunction

  function automatic op_beat_t make_op(logic [2:0] c, logic [31:0] an, logic [31:0] ad,
                                       logic [31:0] bn, logic [31:0] bd);
    op_beat_t o;
    o.cmd = c; o.a_num = an; o.a_den = ad; o.b_num = bn; o.b_den = bd;
    return o;
  endfunction

  // Sender: each beat holds until it is taken; bursts with random gaps between
  // them, so valid never drops and rises in the same step.
  task automatic send_operations();
    op_beat_t o;
    int burst;
    burst = 0;
    while (ops.size() != 0) begin
      if (burst == 0) begin
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst = $urandom_range(1, 12);
      end
      o = ops.pop_front();
      in_valid_i <= 1'b1;
      {cmd_i, a_num_i, a_den_i, b_num_i, b_den_i} <= o;
      do @(posedge clk_i); while (in_stall_o);
      sb.note_operation(o);
      sent++;
      burst--;
      if (burst == 0 || ops.size() == 0) in_valid_i <= 1'b0;
    end
  endtask

  // Result sampling.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{num: res_num_o, den: res_den_o, status: status_o});
  end

  // Receiver stall pattern, with a long hold-off early in the run.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else begin
        n = $urandom_range(0, 15);
        out_stall_i <= (n < 4) || (n == 5 && $urandom_range(0, 1) == 1);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("tb_rational_arithmetic_unit: FAIL");
      $finish;
    end
  end

  initial begin
    logic [2:0] c;
    int drain;
    // Directed: extremes, every command, unused codes, zero and overflow cases.
    for (int k = 0; k <= 7; k++) ops.push_back(make_op(3'(k), 32'd6, 32'd4, 32'd3, 32'hffff_fff7));
    ops.push_back(make_op(CMD_NORM, 32'h8000_0000, 32'hffff_ffff, 0, 0));
    ops.push_back(make_op(CMD_NORM, 32'h8000_0000, 32'd1, 0, 0));
    ops.push_back(make_op(CMD_NORM, 32'd0, 32'h8000_0000, 0, 0));
    ops.push_back(make_op(CMD_NORM, 32'd5, 32'd0, 1, 1));
    ops.push_back(make_op(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd0));
    ops.push_back(make_op(CMD_DIV, 32'd1, 32'd2, 32'd0, 32'd3));
    ops.push_back(make_op(CMD_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1));
    ops.push_back(make_op(CMD_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1));
    ops.push_back(make_op(CMD_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1));
    ops.push_back(make_op(CMD_SUB, 32'd3, 32'd7, 32'd3, 32'd7));
    ops.push_back(make_op(CMD_MUL, 32'd1, 32'h7fff_ffff, 32'd1, 32'd2));
    ops.push_back(make_op(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff));
    ops.push_back(make_op(CMD_ADD, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      ops.push_back(make_op(c, pick_word(), pick_word(), pick_word(), pick_word()));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      send_operations();
      begin
        // Hold the output long enough that the unit backs up its input.
        repeat (150) @(posedge clk_i);
        hold_off = 1'b1;
        repeat (1500) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    while (sb.pending.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 300) begin
      @(posedge clk_i);
      drain++;
    end
    $display("covered %0d operations across all commands, zero and overflow cases,", sent);
    $display("with random input gaps, output stalls and one long output hold-off");
    if (sb.errors == 0) $display("tb_rational_arithmetic_unit: PASS");
    else $display("tb_rational_arithmetic_unit: FAIL");
    $finish;
  end

endmodule

[rational_arithmetic_unit.f]
hw/rtl/rau_pkg.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rau_dp.sv
hw/rtl/rational_arithmetic_unit.sv
dv/tb_rational_arithmetic_unit.sv
